[rtl/dnt_pkg.sv]
package dnt_pkg;

   // input item
   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   // result item as seen on the rsp_ channel
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] position;
      logic [7:0] byte_value;
      logic [2:0] error_code;
      logic       last_result;
   } rsp_type;

   // one result as built by the front, without the last flag
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] position;
      logic [7:0] byte_value;
      logic [2:0] error_code;
   } res_type;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned QUEUE_DEPTH = 4;

   // all results caused by one accepted item
   typedef struct packed {
      logic [2:0]                  count;
      res_type [MAX_RESULTS-1:0]   res;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   localparam logic [1:0] KIND_WRITE    = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_REJECTED = 2'd2;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_EMPTY_LABEL  = 3'd1;
   localparam logic [2:0] ERR_LONG_LABEL   = 3'd2;
   localparam logic [2:0] ERR_OUT_OF_SPACE = 3'd3;
   localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;
   localparam logic [2:0] ERR_ESCAPE_RANGE = 3'd5;

   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [9:0] BYTE_LIMIT     = 10'd255;

   // escape tracking, one-hot
   typedef enum logic [3:0] {
      ESC_NONE  = 4'b0001,
      ESC_SLASH = 4'b0010,
      ESC_ONE   = 4'b0100,
      ESC_TWO   = 4'b1000
   } esc_type;

   function automatic res_type mk_res(logic [1:0] kind, logic [7:0] position,
                                      logic [7:0] byte_value, logic [2:0] error_code);
      res_type r;
      r.kind       = kind;
      r.position   = position;
      r.byte_value = byte_value;
      r.error_code = error_code;
      return r;
   endfunction

endpackage

[rtl/dnt_front.sv]
module dnt_front #(
   parameter int unsigned MAX_LABEL = 63,
   parameter int unsigned MAX_NAME  = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  dnt_pkg::req_type    req,
   input  logic [7:0]          max_length,
   output logic                push,
   output dnt_pkg::entry_type  entry
);

   logic [7:0]       label_start_ff, label_start_in;
   logic [8:0]       write_pos_ff, write_pos_in;
   logic [5:0]       label_count_ff, label_count_in;
   dnt_pkg::esc_type esc_ff, esc_in;
   logic [6:0]       digit_accum_ff, digit_accum_in;
   logic             first_char_ff, first_char_in;
   logic             rejected_ff, rejected_in;

   logic [7:0] cap;
   logic [7:0] ch;
   logic       last;
   logic       is_dec;
   logic [3:0] digit;
   logic [9:0] acc10;

   assign cap    = (max_length < 8'(MAX_NAME)) ? max_length : 8'(MAX_NAME);
   assign ch     = req.character;
   assign last   = req.last_char;
   assign is_dec = (ch >= dnt_pkg::CHAR_ZERO) && (ch <= dnt_pkg::CHAR_NINE);
   assign digit  = ch[3:0];
   assign acc10  = {digit_accum_ff, 3'b000} + {2'b00, digit_accum_ff, 1'b0} + {6'b0, digit};

   dnt_pkg::res_type [dnt_pkg::MAX_RESULTS-1:0] res;
   logic [2:0] n;

   always_comb begin
      logic [7:0]       ls;
      logic [8:0]       wp;
      logic [5:0]       lc;
      dnt_pkg::esc_type esc;
      logic [6:0]       acc;
      logic [2:0]       err;
      logic             tail;
      logic             clr;
      logic             rej;
      ls   = label_start_ff;
      wp   = write_pos_ff;
      lc   = label_count_ff;
      esc  = esc_ff;
      acc  = digit_accum_ff;
      err  = dnt_pkg::ERR_NONE;
      tail = 1'b0;
      clr  = 1'b0;
      rej  = rejected_ff;
      n    = 3'd0;
      res  = '0;

      if (rejected_ff) begin
         if (last) clr = 1'b1;
      end else begin
         unique case (esc_ff)
            dnt_pkg::ESC_NONE: begin
               if (ch == dnt_pkg::CHAR_DOT && first_char_ff && last) begin
                  // root name
                  if (cap == 8'd0) begin
                     err = dnt_pkg::ERR_OUT_OF_SPACE;
                  end else begin
                     res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, 8'd0, 8'd0,
                                                   dnt_pkg::ERR_NONE);
                     n = n + 3'd1;
                     res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_COMPLETE, 8'd1, 8'd0,
                                                   dnt_pkg::ERR_NONE);
                     n = n + 3'd1;
                     clr = 1'b1;
                  end
               end else if (wp >= {1'b0, cap}) begin
                  err = dnt_pkg::ERR_OUT_OF_SPACE;
               end else if (ch == dnt_pkg::CHAR_DOT) begin
                  if (lc == 6'd0) begin
                     err = dnt_pkg::ERR_EMPTY_LABEL;
                  end else begin
                     res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, ls, {2'b00, lc},
                                                   dnt_pkg::ERR_NONE);
                     n  = n + 3'd1;
                     ls = wp[7:0];
                     wp = wp + 9'd1;
                     lc = 6'd0;
                     if (last) begin
                        res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, ls, 8'd0,
                                                      dnt_pkg::ERR_NONE);
                        n = n + 3'd1;
                        res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_COMPLETE, wp[7:0],
                                                      8'd0, dnt_pkg::ERR_NONE);
                        n = n + 3'd1;
                        clr = 1'b1;
                     end
                  end
               end else if (ch == dnt_pkg::CHAR_BACKSLASH) begin
                  if (last) begin
                     err = dnt_pkg::ERR_BAD_ESCAPE;
                  end else if (lc >= 6'(MAX_LABEL)) begin
                     err = dnt_pkg::ERR_LONG_LABEL;
                  end else begin
                     lc  = lc + 6'd1;
                     esc = dnt_pkg::ESC_SLASH;
                  end
               end else begin
                  if (lc >= 6'(MAX_LABEL)) begin
                     err = dnt_pkg::ERR_LONG_LABEL;
                  end else begin
                     res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, wp[7:0], ch,
                                                   dnt_pkg::ERR_NONE);
                     n    = n + 3'd1;
                     wp   = wp + 9'd1;
                     lc   = lc + 6'd1;
                     tail = last;
                  end
               end
            end
            dnt_pkg::ESC_SLASH: begin
               if (is_dec) begin
                  if (last) begin
                     err = dnt_pkg::ERR_BAD_ESCAPE;
                  end else begin
                     acc = {3'b000, digit};
                     esc = dnt_pkg::ESC_ONE;
                  end
               end else begin
                  // escaped literal byte, slot was checked at the backslash
                  res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, wp[7:0], ch,
                                                dnt_pkg::ERR_NONE);
                  n    = n + 3'd1;
                  wp   = wp + 9'd1;
                  esc  = dnt_pkg::ESC_NONE;
                  tail = last;
               end
            end
            dnt_pkg::ESC_ONE: begin
               if (!is_dec || last) begin
                  err = dnt_pkg::ERR_BAD_ESCAPE;
               end else begin
                  acc = acc10[6:0];
                  esc = dnt_pkg::ESC_TWO;
               end
            end
            dnt_pkg::ESC_TWO: begin
               if (!is_dec) begin
                  err = dnt_pkg::ERR_BAD_ESCAPE;
               end else if (acc10 > dnt_pkg::BYTE_LIMIT) begin
                  err = dnt_pkg::ERR_ESCAPE_RANGE;
               end else begin
                  res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, wp[7:0], acc10[7:0],
                                                dnt_pkg::ERR_NONE);
                  n    = n + 3'd1;
                  wp   = wp + 9'd1;
                  esc  = dnt_pkg::ESC_NONE;
                  tail = last;
               end
            end
            default: begin
               esc = dnt_pkg::ESC_NONE;
            end
         endcase

         // closing a name that does not end in a dot
         if (err == dnt_pkg::ERR_NONE && tail) begin
            if (wp >= {1'b0, cap}) begin
               err = dnt_pkg::ERR_OUT_OF_SPACE;
            end else begin
               res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, ls, {2'b00, lc},
                                             dnt_pkg::ERR_NONE);
               n = n + 3'd1;
               res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_WRITE, wp[7:0], 8'd0,
                                             dnt_pkg::ERR_NONE);
               n  = n + 3'd1;
               wp = wp + 9'd1;
               res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_COMPLETE, wp[7:0], 8'd0,
                                             dnt_pkg::ERR_NONE);
               n   = n + 3'd1;
               clr = 1'b1;
            end
         end

         if (err != dnt_pkg::ERR_NONE) begin
            res[n[1:0]] = dnt_pkg::mk_res(dnt_pkg::KIND_REJECTED, 8'd0, 8'd0, err);
            n = n + 3'd1;
            if (last) clr = 1'b1;
            else      rej = 1'b1;
         end
      end

      if (clr) begin
         label_start_in = 8'd0;
         write_pos_in   = 9'd1;
         label_count_in = 6'd0;
         esc_in         = dnt_pkg::ESC_NONE;
         digit_accum_in = 7'd0;
         first_char_in  = 1'b1;
         rejected_in    = 1'b0;
      end else begin
         label_start_in = ls;
         write_pos_in   = wp;
         label_count_in = lc;
         esc_in         = esc;
         digit_accum_in = acc;
         first_char_in  = 1'b0;
         rejected_in    = rej;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_start_ff <= 8'd0;
         write_pos_ff   <= 9'd1;
         label_count_ff <= 6'd0;
         esc_ff         <= dnt_pkg::ESC_NONE;
         digit_accum_ff <= 7'd0;
         first_char_ff  <= 1'b1;
         rejected_ff    <= 1'b0;
      end else if (accept) begin
         label_start_ff <= label_start_in;
         write_pos_ff   <= write_pos_in;
         label_count_ff <= label_count_in;
         esc_ff         <= esc_in;
         digit_accum_ff <= digit_accum_in;
         first_char_ff  <= first_char_in;
         rejected_ff    <= rejected_in;
      end
   end

   assign push        = accept && (n != 3'd0);
   assign entry.count = n;
   assign entry.res   = res;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      write_pos_ff >= 9'd1 && write_pos_ff <= 9'd256)
      else $error("write position out of range");

endmodule

[rtl/dnt_queue.sv]
module dnt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dnt_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output dnt_pkg::head_type   head
);

   localparam int unsigned PTR_W = $clog2(dnt_pkg::QUEUE_DEPTH);

   dnt_pkg::entry_type mem_ff [dnt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == (PTR_W+1)'(dnt_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (PTR_W+1)'(1);
      if (!do_push && do_pop) count_in = count_ff - (PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(dnt_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + (PTR_W+1)'(1))
      else $error("queue count did not grow on push");

endmodule

[rtl/dnt_back.sv]
module dnt_back (
   input  logic               clock,
   input  logic               reset,
   input  dnt_pkg::head_type  head,
   output logic               entry_done,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output dnt_pkg::rsp_type   rsp_item
);

   logic [1:0]       idx_ff, idx_in;
   dnt_pkg::res_type cur;
   logic             is_last;
   logic             take;

   assign cur       = head.entry.res[idx_ff];
   assign is_last   = ({1'b0, idx_ff} + 3'd1) == head.entry.count;
   assign rsp_empty = !head.valid;
   assign take      = rsp_pop && head.valid;

   assign rsp_item.kind        = cur.kind;
   assign rsp_item.position    = cur.position;
   assign rsp_item.byte_value  = cur.byte_value;
   assign rsp_item.error_code  = cur.error_code;
   assign rsp_item.last_result = is_last;

   // retire the entry with its final result
   assign entry_done = take && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else       idx_ff <= idx_in;
   end

   a_idx_in_entry: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> head.entry.count != 3'd0 && {1'b0, idx_ff} < head.entry.count)
      else $error("result index outside queued entry");

endmodule

[rtl/dns_name_text_to_wire.sv]
// Streaming encoder from presentation-format domain name text to wire format.
// req_ channel: one character per item (req_push / req_full). An item is taken
// on any edge with req_push high and req_full low; up to one item per cycle.
// rsp_ channel: results are byte writes at positions, then a complete result
// with the total length, or one rejected result with an error code. The oldest
// result sits on rsp_item while rsp_empty is low and leaves on rsp_pop.
// csr_ channel: writes max_length; csr_ready is always high. Write it only
// while no name is in flight.
// The queue registers an item's results before they reach rsp_item.
// Items are taken one per cycle while req_full is low; the back end drains one
// result per cycle while rsp_pop is high, so an item with k results (k up to 4)
// holds the output until all k are popped. A four-entry queue between the front
// and back ends absorbs that; a stalled receiver fills it and req_full rises.
// Reset: synchronous, clears name state and the queue, max_length becomes 255.
module dns_name_text_to_wire #(
   parameter int unsigned MAX_LABEL = 63,
   parameter int unsigned MAX_NAME  = 255
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dnt_pkg::req_type  req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dnt_pkg::rsp_type  rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   logic [7:0]         max_length_ff;
   logic               accept;
   logic               push;
   dnt_pkg::entry_type entry;
   dnt_pkg::head_type  head;
   logic               entry_done;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset)                      max_length_ff <= 8'd255;
      else if (csr_valid && csr_ready) max_length_ff <= csr_data;
   end

   dnt_front #(
      .MAX_LABEL (MAX_LABEL),
      .MAX_NAME  (MAX_NAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_item),
      .max_length (max_length_ff),
      .push       (push),
      .entry      (entry)
   );

   dnt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (entry_done),
      .full       (req_full),
      .head       (head)
   );

   dnt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .entry_done (entry_done),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

[verif/dns_wire_checker.sv]
`timescale 1ns / 1ps

module dns_wire_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  dnt_pkg::req_type req_item,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  dnt_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [7:0]       csr_data,
   output int               failures,
   output int               pending,
   output int               results_checked,
   output int               names_complete,
   output int               names_rejected
);

   localparam int unsigned LABEL_LIMIT = 63;

   // predicted encoder state
   logic [7:0]       max_len;
   logic [7:0]       lstart;
   logic [8:0]       wpos;
   logic [5:0]       lcount;
   dnt_pkg::esc_type esc;
   logic [9:0]       accum;
   logic             name_start;
   logic             swallowing;

   dnt_pkg::rsp_type wire_expect[$];
   dnt_pkg::rsp_type batch [dnt_pkg::MAX_RESULTS];
   int               batch_n;
   int               fail_count;
   int               checked;
   int               completes;
   int               rejects;

   function automatic void restart_name();
      lstart     = 8'd0;
      wpos       = 9'd1;
      lcount     = 6'd0;
      esc        = dnt_pkg::ESC_NONE;
      accum      = 10'd0;
      name_start = 1'b1;
      swallowing = 1'b0;
   endfunction

   function automatic void emit_wire(logic [1:0] k, logic [7:0] p, logic [7:0] v,
                                     logic [2:0] e);
      batch[batch_n] = '{kind: k, position: p, byte_value: v, error_code: e,
                         last_result: 1'b0};
      batch_n++;
   endfunction

   function automatic logic dec_char(logic [7:0] c);
      return c >= dnt_pkg::CHAR_ZERO && c <= dnt_pkg::CHAR_NINE;
   endfunction

   task automatic encode_char(input logic [7:0] ch, input logic fin);
      logic             opener;
      logic             tail;
      logic [2:0]       err;
      logic [9:0]       num;
      dnt_pkg::rsp_type r;
      opener     = name_start;
      tail       = 1'b0;
      err        = dnt_pkg::ERR_NONE;
      batch_n    = 0;
      name_start = 1'b0;
      if (swallowing) begin
         if (fin) restart_name();
      end else begin
         case (esc)
            dnt_pkg::ESC_NONE: begin
               if (ch == dnt_pkg::CHAR_DOT && opener && fin) begin
                  // root name
                  if (max_len == 8'd0) begin
                     err = dnt_pkg::ERR_OUT_OF_SPACE;
                  end else begin
                     emit_wire(dnt_pkg::KIND_WRITE, 8'd0, 8'd0, dnt_pkg::ERR_NONE);
                     emit_wire(dnt_pkg::KIND_COMPLETE, 8'd1, 8'd0, dnt_pkg::ERR_NONE);
                     restart_name();
                  end
               end else if (wpos >= {1'b0, max_len}) begin
                  err = dnt_pkg::ERR_OUT_OF_SPACE;
               end else if (ch == dnt_pkg::CHAR_DOT) begin
                  if (lcount == 6'd0) begin
                     err = dnt_pkg::ERR_EMPTY_LABEL;
                  end else begin
                     emit_wire(dnt_pkg::KIND_WRITE, lstart, 8'(lcount), dnt_pkg::ERR_NONE);
                     lstart = wpos[7:0];
                     wpos++;
                     lcount = 6'd0;
                     if (fin) begin
                        emit_wire(dnt_pkg::KIND_WRITE, lstart, 8'd0, dnt_pkg::ERR_NONE);
                        emit_wire(dnt_pkg::KIND_COMPLETE, wpos[7:0], 8'd0,
                                  dnt_pkg::ERR_NONE);
                        restart_name();
                     end
                  end
               end else if (ch == dnt_pkg::CHAR_BACKSLASH) begin
                  if (fin) begin
                     err = dnt_pkg::ERR_BAD_ESCAPE;
                  end else if (lcount >= LABEL_LIMIT) begin
                     err = dnt_pkg::ERR_LONG_LABEL;
                  end else begin
                     lcount++;
                     esc = dnt_pkg::ESC_SLASH;
                  end
               end else if (lcount >= LABEL_LIMIT) begin
                  err = dnt_pkg::ERR_LONG_LABEL;
               end else begin
                  emit_wire(dnt_pkg::KIND_WRITE, wpos[7:0], ch, dnt_pkg::ERR_NONE);
                  wpos++;
                  lcount++;
                  tail = fin;
               end
            end
            dnt_pkg::ESC_SLASH: begin
               if (dec_char(ch)) begin
                  if (fin) begin
                     err = dnt_pkg::ERR_BAD_ESCAPE;
                  end else begin
                     accum = 10'(ch - dnt_pkg::CHAR_ZERO);
                     esc   = dnt_pkg::ESC_ONE;
                  end
               end else begin
                  // escaped literal, slot already checked at the backslash
                  emit_wire(dnt_pkg::KIND_WRITE, wpos[7:0], ch, dnt_pkg::ERR_NONE);
                  wpos++;
                  esc  = dnt_pkg::ESC_NONE;
                  tail = fin;
               end
            end
            dnt_pkg::ESC_ONE: begin
               if (!dec_char(ch) || fin) begin
                  err = dnt_pkg::ERR_BAD_ESCAPE;
               end else begin
                  accum = accum * 10 + 10'(ch - dnt_pkg::CHAR_ZERO);
                  esc   = dnt_pkg::ESC_TWO;
               end
            end
            default: begin
               if (!dec_char(ch)) begin
                  err = dnt_pkg::ERR_BAD_ESCAPE;
               end else begin
                  num = accum * 10 + 10'(ch - dnt_pkg::CHAR_ZERO);
                  if (num > dnt_pkg::BYTE_LIMIT) begin
                     err = dnt_pkg::ERR_ESCAPE_RANGE;
                  end else begin
                     emit_wire(dnt_pkg::KIND_WRITE, wpos[7:0], num[7:0], dnt_pkg::ERR_NONE);
                     wpos++;
                     esc  = dnt_pkg::ESC_NONE;
                     tail = fin;
                  end
               end
            end
         endcase

         // name ends without a trailing dot: close label and add the terminal byte
         if (err == dnt_pkg::ERR_NONE && tail) begin
            if (wpos >= {1'b0, max_len}) begin
               err = dnt_pkg::ERR_OUT_OF_SPACE;
            end else begin
               emit_wire(dnt_pkg::KIND_WRITE, lstart, 8'(lcount), dnt_pkg::ERR_NONE);
               emit_wire(dnt_pkg::KIND_WRITE, wpos[7:0], 8'd0, dnt_pkg::ERR_NONE);
               wpos++;
               emit_wire(dnt_pkg::KIND_COMPLETE, wpos[7:0], 8'd0, dnt_pkg::ERR_NONE);
               restart_name();
            end
         end

         if (err != dnt_pkg::ERR_NONE) begin
            emit_wire(dnt_pkg::KIND_REJECTED, 8'd0, 8'd0, err);
            if (fin) restart_name();
            else swallowing = 1'b1;
         end
      end

      for (int i = 0; i < batch_n; i++) begin
         r = batch[i];
         r.last_result = (i == batch_n - 1);
         wire_expect.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      dnt_pkg::rsp_type want;
      if (reset) begin
         wire_expect.delete();
         max_len    = 8'd255;
         restart_name();
         fail_count = 0;
         checked    = 0;
         completes  = 0;
         rejects    = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (rsp_item.kind == dnt_pkg::KIND_COMPLETE) completes++;
            if (rsp_item.kind == dnt_pkg::KIND_REJECTED) rejects++;
            if (wire_expect.size() == 0) begin
               $display("%0t unexpected result: kind=%0d pos=%0d byte=%0h err=%0d last=%0b",
                        $time, rsp_item.kind, rsp_item.position, rsp_item.byte_value,
                        rsp_item.error_code, rsp_item.last_result);
               fail_count++;
            end else begin
               want = wire_expect.pop_front();
               checked++;
               if (rsp_item !== want) begin
                  $display("%0t mismatch: expected kind=%0d pos=%0d byte=%0h err=%0d last=%0b",
                           $time, want.kind, want.position, want.byte_value,
                           want.error_code, want.last_result);
                  $display("%0t          actual   kind=%0d pos=%0d byte=%0h err=%0d last=%0b",
                           $time, rsp_item.kind, rsp_item.position, rsp_item.byte_value,
                           rsp_item.error_code, rsp_item.last_result);
                  fail_count++;
               end
            end
         end

         // an item taken at this edge still sees the old max_length
         if (req_push && !req_full) encode_char(req_item.character, req_item.last_char);

         if (csr_valid && csr_ready) max_len = csr_data;
      end
      pending         <= wire_expect.size();
      failures        <= fail_count;
      results_checked <= checked;
      names_complete  <= completes;
      names_rejected  <= rejects;
   end

endmodule

[verif/dns_name_text_to_wire_tb.sv]
`timescale 1ns / 1ps

module dns_name_text_to_wire_tb;

   localparam int ITEM_TARGET = 340;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   dnt_pkg::req_type req_item;
   logic             rsp_empty;
   logic             rsp_pop;
   dnt_pkg::rsp_type rsp_item;
   logic             csr_valid;
   logic             csr_ready;
   logic [7:0]       csr_data;

   int failures;
   int pending;
   int results_checked;
   int names_complete;
   int names_rejected;

   bit idle_in;
   bit idle_out;
   bit hold_rsp;
   int items_sent;
   int settings_used;

   logic [7:0] text[$];
   logic [7:0] cap_plan [6] = '{8'd255, 8'd9, 8'd20, 8'd1, 8'd64, 8'd255};

   dns_name_text_to_wire uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dns_wire_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_item        (req_item),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_item        (rsp_item),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked),
      .names_complete  (names_complete),
      .names_rejected  (names_rejected)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side
   initial begin
      int gap;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            // long stall so the internal queue fills and req_full rises
            hold_rsp = 1'b0;
            rsp_pop <= 1'b0;
            repeat (300) @(posedge clock);
         end
         gap = idle_out ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic fin);
      int gap;
      gap = idle_in ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{character: ch, last_char: fin};
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_str(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(8'(s[i]));
      send_text();
   endtask

   // stop offering items and wait until every predicted result is out
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // items that cause no result may still be in the front end
      repeat (8) @(posedge clock);
   endtask

   task automatic set_max_length(input logic [7:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] pick_digit();
      return 8'(dnt_pkg::CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_nondigit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c >= dnt_pkg::CHAR_ZERO && c <= dnt_pkg::CHAR_NINE);
      return c;
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      if ($urandom_range(0, 4) != 0) return 8'("a" + $urandom_range(0, 25));
      do c = 8'($urandom_range(0, 255));
      while (c == dnt_pkg::CHAR_DOT || c == dnt_pkg::CHAR_BACKSLASH);
      return c;
   endfunction

   // one label byte: plain, escaped literal or decimal escape
   task automatic add_label_byte();
      int pick;
      int v;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         text.push_back(dnt_pkg::CHAR_BACKSLASH);
         text.push_back(pick_nondigit());
      end else if (pick == 1) begin
         v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
         text.push_back(dnt_pkg::CHAR_BACKSLASH);
         text.push_back(8'(dnt_pkg::CHAR_ZERO + v / 100));
         text.push_back(8'(dnt_pkg::CHAR_ZERO + (v / 10) % 10));
         text.push_back(8'(dnt_pkg::CHAR_ZERO + v % 10));
      end else begin
         text.push_back(pick_plain());
      end
   endtask

   task automatic make_name();
      int shape;
      int labels;
      int len;
      text.delete();
      shape = $urandom_range(0, 99);
      if (shape < 5) begin
         text.push_back(dnt_pkg::CHAR_DOT);
      end else if (shape < 15) begin
         len = $urandom_range(1, 10);
         repeat (len) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         labels = $urandom_range(1, 4);
         for (int l = 0; l < labels; l++) begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
            repeat (len) add_label_byte();
            if (l < labels - 1 || $urandom_range(0, 1) == 1) text.push_back(dnt_pkg::CHAR_DOT);
         end
         if (shape >= 85) begin
            // broken tails and misplaced dots
            case ($urandom_range(0, 6))
               0: text.push_back(dnt_pkg::CHAR_BACKSLASH);
               1: begin
                  text.push_back(dnt_pkg::CHAR_BACKSLASH);
                  text.push_back(pick_digit());
               end
               2: begin
                  text.push_back(dnt_pkg::CHAR_BACKSLASH);
                  text.push_back(pick_digit());
                  text.push_back(pick_digit());
               end
               3: text.insert($urandom_range(0, text.size() - 1), dnt_pkg::CHAR_DOT);
               4: text.push_front(dnt_pkg::CHAR_DOT);
               5: begin
                  text.push_back(dnt_pkg::CHAR_BACKSLASH);
                  text.push_back(pick_digit());
                  text.push_back(pick_nondigit());
                  text.push_back(pick_plain());
               end
               default: begin
                  text.push_back(dnt_pkg::CHAR_BACKSLASH);
                  text.push_back(pick_digit());
                  text.push_back(pick_digit());
                  text.push_back(pick_nondigit());
               end
            endcase
         end
      end
   endtask

   initial begin
      int phase;
      int stop;
      int w;
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= 8'd255;
      idle_in       = 1'b0;
      idle_out      = 1'b0;
      hold_rsp      = 1'b0;
      items_sent    = 0;
      settings_used = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed names, back to back
      send_str(".");
      send_str("a");
      send_str("ab.");
      send_str("\\");
      send_str("..");
      send_str("\\255");
      send_str("\\256");
      send_str("\\1");
      send_str("\\1x");
      send_char(dnt_pkg::CHAR_BACKSLASH, 1'b0);
      send_char(8'h00, 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);

      // zero and minimum capacity
      set_max_length(8'd0);
      send_str(".");
      send_str("a");
      set_max_length(8'd1);
      send_str(".");
      send_str("a");

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         set_max_length(phase < 6 ? cap_plan[phase] : 8'($urandom_range(1, 48)));
         idle_in  = phase[0];
         idle_out = phase[1];
         if (phase == 2) hold_rsp = 1'b1;
         if (phase == 0) begin
            // longest legal label, then one byte too many
            for (int k = 63; k <= 64; k++) begin
               text.delete();
               repeat (k) text.push_back(pick_plain());
               text.push_back(dnt_pkg::CHAR_DOT);
               send_text();
            end
         end
         stop = items_sent + 45;
         while (items_sent < stop) begin
            make_name();
            send_text();
         end
         phase++;
      end
      req_push <= 1'b0;

      for (w = 0; w < 5000 && pending != 0; w++) @(posedge clock);
      if (pending != 0) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         $display("run covered %0d characters over %0d max_length settings",
                  items_sent, settings_used);
         $display("%0d results checked, %0d names encoded, %0d names rejected",
                  results_checked, names_complete, names_rejected);
         if (failures == 0 && pending == 0) begin
            $display("== PASS ==");
         end else begin
            $display("== FAIL ==");
         end
         $finish;
      end
   end

endmodule

[sim.f]
rtl/dnt_pkg.sv
rtl/dnt_front.sv
rtl/dnt_queue.sv
rtl/dnt_back.sv
rtl/dns_name_text_to_wire.sv
verif/dns_wire_checker.sv
verif/dns_name_text_to_wire_tb.sv
